### rtl/core/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and calendar helpers
// Item and result records, the shared adder request and month/year lengths
// for the date-time / seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  // Units peeled off the remaining second count
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;

  // Whole years and months expressed in seconds
  localparam logic [31:0] SECS_PER_YEAR      = 32'd31536000;
  localparam logic [31:0] SECS_PER_LEAP_YEAR = 32'd31622400;
  localparam logic [31:0] SECS_PER_28_DAYS   = 32'd2419200;
  localparam logic [31:0] SECS_PER_29_DAYS   = 32'd2505600;
  localparam logic [31:0] SECS_PER_30_DAYS   = 32'd2592000;
  localparam logic [31:0] SECS_PER_31_DAYS   = 32'd2678400;

  // Last legal value of each date-time input field
  localparam logic [7:0] YEAR_LAST   = 8'd99;
  localparam logic [7:0] MONTH_LAST  = 8'd12;
  localparam logic [7:0] DAY_LAST    = 8'd31;
  localparam logic [7:0] HOUR_LAST   = 8'd23;
  localparam logic [7:0] MINSEC_LAST = 8'd59;

  // One input item
  typedef struct packed {
    logic        op;
    logic [7:0]  year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [31:0] seconds;
  } dsc_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] seconds;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        error;
  } dsc_result_t;

  // Request to the shared adder: a + b, or a - b when sub is set
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } dsc_alu_req_t;

  // Offsets 0..99 from 2000: divisible by four is leap (2000 itself included)
  function automatic logic is_leap(input logic [6:0] year_off);
    return (year_off[1:0] == 2'b00);
  endfunction

  function automatic logic [8:0] days_of_year(input logic [6:0] year_off);
    return is_leap(year_off) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] days_of_month(input logic [6:0] year_off,
                                               input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = is_leap(year_off) ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [31:0] secs_of_year(input logic [6:0] year_off);
    return is_leap(year_off) ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR;
  endfunction

  function automatic logic [31:0] secs_of_month(input logic [6:0] year_off,
                                                input logic [3:0] month);
    logic [31:0] secs;
    case (days_of_month(year_off, month))
      5'd28:   secs = SECS_PER_28_DAYS;
      5'd29:   secs = SECS_PER_29_DAYS;
      5'd30:   secs = SECS_PER_30_DAYS;
      default: secs = SECS_PER_31_DAYS;
    endcase
    return secs;
  endfunction

endpackage

`default_nettype wire

### rtl/core/dsc_alu.sv
// ----------------------------------------------------------------------------
// dsc_alu: shared 32-bit adder / subtractor
// The one arithmetic unit of the converter. The carry out of a subtraction
// is set when a >= b and serves as the compare result.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_alu
  import dsc_pkg::*;
(
  input  dsc_alu_req_t req,
  output logic [31:0]  res,
  output logic         carry
);

  logic [31:0] b_eff;
  logic [32:0] sum;

  // Invert b and add one for a subtraction
  assign b_eff = req.sub ? ~req.b : req.b;
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, req.sub};
  assign res   = sum[31:0];
  assign carry = sum[32];

endmodule

`default_nettype wire

### rtl/core/dsc_engine.sv
// ----------------------------------------------------------------------------
// dsc_engine: conversion sequencer
// Walks years and months, peels days, hours and minutes off a second count by
// repeated subtraction and builds the second count by shift-and-add, all
// through one shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_engine
  import dsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  dsc_item_t   item,
  output logic        idle,
  output logic        res_valid,
  input  logic        res_ready,
  output dsc_result_t res
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SPLIT  = 6'b000010,
    ST_YEAR   = 6'b000100,
    ST_MONTH  = 6'b001000,
    ST_HORNER = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PH_DAY  = 2'd0,
    PH_HOUR = 2'd1,
    PH_MIN  = 2'd2
  } phase_t;

  // Steps of the seconds build: ((days*24 + h)*60 + m)*60 + s
  localparam logic [2:0] HS_DAY  = 3'd0;
  localparam logic [2:0] HS_X24  = 3'd1;
  localparam logic [2:0] HS_HOUR = 3'd2;
  localparam logic [2:0] HS_X60A = 3'd3;
  localparam logic [2:0] HS_MIN  = 3'd4;
  localparam logic [2:0] HS_X60B = 3'd5;
  localparam logic [2:0] HS_SEC  = 3'd6;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic        op_r, op_nxt;
  logic        err_r, err_nxt;
  logic [6:0]  yr_r, yr_nxt;
  logic [3:0]  mo_r, mo_nxt;
  logic [4:0]  dy_r, dy_nxt;
  logic [4:0]  hr_r, hr_nxt;
  logic [5:0]  mi_r, mi_nxt;
  logic [5:0]  se_r, se_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [6:0]  cnt_y_r, cnt_y_nxt;
  logic [3:0]  cnt_m_r, cnt_m_nxt;
  logic [2:0]  step_r, step_nxt;

  dsc_alu_req_t alu_req;
  logic [31:0]  alu_res;
  logic         alu_carry;

  logic [31:0]  divisor;
  logic [31:0]  year_len;
  logic [31:0]  month_len;
  logic [6:0]   dom_year;
  logic         bad_time;

  dsc_alu u_alu (
    .req   (alu_req),
    .res   (alu_res),
    .carry (alu_carry)
  );

  // Unit taken off the remaining seconds in each split phase
  always_comb begin
    case (phase_r)
      PH_DAY:  divisor = SECS_PER_DAY;
      PH_HOUR: divisor = SECS_PER_HOUR;
      default: divisor = SECS_PER_MIN;
    endcase
  end

  assign dom_year = op_r ? cnt_y_r : yr_r;

  // Year and month lengths: in days when building, in seconds when splitting
  assign year_len  = op_r ? secs_of_year(cnt_y_r) : {23'd0, days_of_year(cnt_y_r)};
  assign month_len = op_r ? secs_of_month(dom_year, cnt_m_r)
                          : {27'd0, days_of_month(dom_year, cnt_m_r)};

  assign bad_time = (item.year > YEAR_LAST) || (item.month == 8'd0) ||
                    (item.month > MONTH_LAST) || (item.day == 8'd0) ||
                    (item.day > DAY_LAST) || (item.hour > HOUR_LAST) ||
                    (item.minute > MINSEC_LAST) || (item.second > MINSEC_LAST);

  // Sequencer and datapath next values
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    err_nxt   = err_r;
    yr_nxt    = yr_r;
    mo_nxt    = mo_r;
    dy_nxt    = dy_r;
    hr_nxt    = hr_r;
    mi_nxt    = mi_r;
    se_nxt    = se_r;
    acc_nxt   = acc_r;
    cnt_y_nxt = cnt_y_r;
    cnt_m_nxt = cnt_m_r;
    step_nxt  = step_r;
    alu_req   = '{a: acc_r, b: 32'd0, sub: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = item.op;
          yr_nxt    = item.year[6:0];
          mo_nxt    = item.month[3:0];
          dy_nxt    = item.day[4:0];
          hr_nxt    = item.hour[4:0];
          mi_nxt    = item.minute[5:0];
          se_nxt    = item.second[5:0];
          acc_nxt   = item.op ? item.seconds : 32'd0;
          cnt_y_nxt = 7'd0;
          err_nxt   = item.op ? item.seconds[31] : bad_time;
          if ((item.op && item.seconds[31]) || (!item.op && bad_time)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_YEAR;
          end
        end
      end

      // Peel one day, hour or minute off the remaining seconds per cycle
      ST_SPLIT: begin
        alu_req = '{a: acc_r, b: divisor, sub: 1'b1};
        if (alu_carry) begin
          acc_nxt = alu_res;
          case (phase_r)
            PH_DAY:  dy_nxt = dy_r + 5'd1;
            PH_HOUR: hr_nxt = hr_r + 5'd1;
            default: mi_nxt = mi_r + 6'd1;
          endcase
        end else begin
          case (phase_r)
            PH_DAY:  phase_nxt = PH_HOUR;
            PH_HOUR: phase_nxt = PH_MIN;
            default: begin
              se_nxt    = acc_r[5:0];
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Add whole years, or peel them off the second count
      ST_YEAR: begin
        alu_req = '{a: acc_r, b: year_len, sub: op_r};
        if (op_r) begin
          if (alu_carry) begin
            acc_nxt   = alu_res;
            cnt_y_nxt = cnt_y_r + 7'd1;
          end else begin
            cnt_m_nxt = 4'd1;
            state_nxt = ST_MONTH;
          end
        end else if (cnt_y_r == yr_r) begin
          cnt_m_nxt = 4'd1;
          state_nxt = ST_MONTH;
        end else begin
          acc_nxt   = alu_res;
          cnt_y_nxt = cnt_y_r + 7'd1;
        end
      end

      // Add whole months, or peel them off the second count
      ST_MONTH: begin
        alu_req = '{a: acc_r, b: month_len, sub: op_r};
        if (op_r) begin
          if (alu_carry) begin
            acc_nxt   = alu_res;
            cnt_m_nxt = cnt_m_r + 4'd1;
          end else begin
            dy_nxt    = 5'd1;
            hr_nxt    = 5'd0;
            mi_nxt    = 6'd0;
            phase_nxt = PH_DAY;
            state_nxt = ST_SPLIT;
          end
        end else if (cnt_m_r == mo_r) begin
          step_nxt  = HS_DAY;
          state_nxt = ST_HORNER;
        end else begin
          acc_nxt   = alu_res;
          cnt_m_nxt = cnt_m_r + 4'd1;
        end
      end

      // Scale and add the time of day, one adder pass a cycle
      ST_HORNER: begin
        acc_nxt  = alu_res;
        step_nxt = step_r + 3'd1;
        case (step_r)
          HS_DAY:  alu_req = '{a: acc_r, b: {27'd0, dy_r - 5'd1}, sub: 1'b0};
          HS_X24:  alu_req = '{a: {acc_r[27:0], 4'd0}, b: {acc_r[28:0], 3'd0}, sub: 1'b0};
          HS_HOUR: alu_req = '{a: acc_r, b: {27'd0, hr_r}, sub: 1'b0};
          HS_X60A: alu_req = '{a: {acc_r[25:0], 6'd0}, b: {acc_r[29:0], 2'd0}, sub: 1'b1};
          HS_MIN:  alu_req = '{a: acc_r, b: {26'd0, mi_r}, sub: 1'b0};
          HS_X60B: alu_req = '{a: {acc_r[25:0], 6'd0}, b: {acc_r[29:0], 2'd0}, sub: 1'b1};
          HS_SEC: begin
            alu_req   = '{a: acc_r, b: {26'd0, se_r}, sub: 1'b0};
            state_nxt = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    op_r    <= op_nxt;
    err_r   <= err_nxt;
    yr_r    <= yr_nxt;
    mo_r    <= mo_nxt;
    dy_r    <= dy_nxt;
    hr_r    <= hr_nxt;
    mi_r    <= mi_nxt;
    se_r    <= se_nxt;
    acc_r   <= acc_nxt;
    cnt_y_r <= cnt_y_nxt;
    cnt_m_r <= cnt_m_nxt;
    step_r  <= step_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  // Assemble the result; unused fields stay zero
  always_comb begin
    res = '0;
    if (err_r) begin
      res.error = 1'b1;
    end else if (!op_r) begin
      res.seconds = acc_r;
    end else begin
      res.year   = cnt_y_r;
      res.month  = cnt_m_r;
      res.day    = dy_r;
      res.hour   = hr_r;
      res.minute = mi_r;
      res.second = se_r;
    end
  end

  a_split_below_day: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPLIT && phase_r != PH_DAY) |-> (acc_r < SECS_PER_DAY))
    else $error("time of day left over exceeds one day");

  a_month_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH) |-> (cnt_m_r >= 4'd1 && cnt_m_r <= 4'd12))
    else $error("month walk left the year");

  a_year_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR && !op_r) |-> (cnt_y_r <= yr_r))
    else $error("year walk passed the target year");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && idle) |=> (state_r != ST_IDLE))
    else $error("accepted item did not start a conversion");

endmodule

`default_nettype wire

### rtl/core/datetime_seconds_converter.sv
// ----------------------------------------------------------------------------
// datetime_seconds_converter: calendar date-time <-> seconds since 2000
// Converts a date-time to seconds since 2000-01-01 00:00:00 or back, with
// range checking, through one shared adder and a registered output stage.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                    Handshake
//  in_       slave      tdata: y,mo,d,h,mi,s,seconds; tuser: op     tvalid/tready
//  out_      master     tdata: seconds,y,mo,d,h,mi,s; tuser: error  tvalid/tready
//
//  Date-time to seconds: whole years and then whole months are added in days,
//  after which the time of day is scaled and added by shift-and-add.
//  Seconds to date-time: years and then months are walked one at a time, then
//  days, hours and minutes are peeled off, each phase closed by a failed compare.
//  Out-of-range items go straight to the result with the error flag set. Every
//  calendar step goes through the single 32-bit adder.
//  Reset (rst_n low, synchronous) returns the sequencer to idle and empties
//  the output register. in_tready is high only while the sequencer is idle;
//  a finished result waits in the output register while out_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module datetime_seconds_converter
  import dsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // year[7:0], month[15:8], day[23:16], hour[31:24], minute[39:32],
  // second[47:40], seconds_in[79:48]
  input  wire logic [79:0] in_tdata,
  // op[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // seconds_out[31:0], year_out[38:32], month_out[42:39], day_out[47:43],
  // hour_out[52:48], minute_out[58:53], second_out[64:59], zero[71:65]
  output logic [71:0]      out_tdata,
  // error[0]
  output logic             out_tuser
);

  dsc_item_t   item;
  dsc_result_t eng_res;
  logic        eng_idle;
  logic        eng_valid;
  logic        eng_ready;
  logic        start;

  logic        out_valid_r, out_valid_nxt;
  dsc_result_t out_data_r;

  // Unpack the input item
  assign item.op      = in_tuser;
  assign item.year    = in_tdata[7:0];
  assign item.month   = in_tdata[15:8];
  assign item.day     = in_tdata[23:16];
  assign item.hour    = in_tdata[31:24];
  assign item.minute  = in_tdata[39:32];
  assign item.second  = in_tdata[47:40];
  assign item.seconds = in_tdata[79:48];

  assign in_tready = eng_idle;
  assign start     = in_tvalid && eng_idle;

  dsc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .idle      (eng_idle),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res       (eng_res)
  );

  // Output register: take a new result when empty or being drained
  assign eng_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = eng_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid && eng_ready) begin
      out_data_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.second, out_data_r.minute, out_data_r.hour,
                       out_data_r.day, out_data_r.month, out_data_r.year,
                       out_data_r.seconds};
  assign out_tuser  = out_data_r.error;

endmodule

`default_nettype wire
